FILE: sv/sqlrs_pkg.sv
// ----------------------------------------------------------------------------
// sqlrs_pkg
// Types and constants for the result-set packet sniffer.
// ----------------------------------------------------------------------------
package sqlrs_pkg;

  // parse phase of the packet framer
  typedef enum logic [1:0] {
    PH_HEADER    = 2'd0,
    PH_PAYLOAD   = 2'd1,
    PH_FINAL_OK  = 2'd2,
    PH_FINAL_ERR = 2'd3
  } phase_e;

  // response status as seen on the result port
  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_DONE_OK  = 2'd1,
    ST_DONE_ERR = 2'd2
  } status_e;

  localparam int unsigned LenBits     = 24;
  localparam int unsigned ColBits     = 16;
  localparam int unsigned HdrIdxBits  = 2;
  localparam int unsigned EofCntBits  = 2;

  localparam logic [HdrIdxBits-1:0] HDR_LEN_B0  = 2'd0;
  localparam logic [HdrIdxBits-1:0] HDR_LEN_B1  = 2'd1;
  localparam logic [HdrIdxBits-1:0] HDR_LEN_B2  = 2'd2;
  localparam logic [HdrIdxBits-1:0] HDR_SEQ     = 2'd3;

  localparam logic [7:0] ERR_MARK = 8'hFF;
  localparam logic [7:0] OK_MARK  = 8'h00;
  localparam logic [7:0] EOF_MARK = 8'hFE;

  localparam logic [LenBits-1:0] EOF_LEN_LIMIT = 24'd9;

  localparam logic [EofCntBits-1:0] EOF_NONE = 2'd0;
  localparam logic [EofCntBits-1:0] EOF_ONE  = 2'd1;
  localparam logic [EofCntBits-1:0] EOF_TWO  = 2'd2;

endpackage

FILE: sv/sql_resultset_packet_sniffer_top.sv
// ----------------------------------------------------------------------------
// sql_resultset_packet_sniffer_top
// Frames a text query response byte by byte and reports status and counts.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one response byte per
//   item, with starts_response_i set on the first byte of a new response,
//   which clears all counters and parse state.
//   The output channel (out_valid_o / out_stall_i) returns one item per input
//   item: status, column, row and byte counts after that byte, and
//   response_done_o on the byte that ends the response.
//   An accepted byte's result is registered and shows from the next cycle on.
//   Throughput is one byte per cycle unless the receiver stalls, set by the
//   single state update between the parse registers and the result register.
//   When the receiver stalls, the result register holds its item and the
//   input is stalled in the same cycle; it is released as soon as the result
//   is taken, so no cycle is lost while the output flows.
//   After reset the block is idle, with no result pending, and treats the
//   stream as a fresh response. Bytes after a completed response are taken
//   but change nothing until the next start mark.
// ----------------------------------------------------------------------------
module sql_resultset_packet_sniffer_top
  import sqlrs_pkg::*;
#(
  parameter int unsigned ROW_COUNT_BITS  = 32,
  parameter int unsigned BYTE_COUNT_BITS = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       starts_response_i,

  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [ColBits-1:0]         column_count_o,
  output logic [ROW_COUNT_BITS-1:0]  row_count_o,
  output logic [BYTE_COUNT_BITS-1:0] byte_count_o,
  output logic                       response_done_o
);

  // parse state
  phase_e                     phase_q,    phase_d;
  logic [HdrIdxBits-1:0]      hdr_idx_q,  hdr_idx_d;
  logic [LenBits-1:0]         pkt_len_q,  pkt_len_d;
  logic [LenBits-1:0]         left_q,     left_d;
  logic                       first_q,    first_d;
  logic [EofCntBits-1:0]      eof_q,      eof_d;
  status_e                    resp_q,     resp_d;
  logic [ColBits-1:0]         cols_q,     cols_d;
  logic [ROW_COUNT_BITS-1:0]  rows_q,     rows_d;
  logic [BYTE_COUNT_BITS-1:0] bytes_q,    bytes_d;
  logic                       done_d;

  // result register
  logic                       out_valid_q;
  status_e                    status_q;
  logic [ColBits-1:0]         col_out_q;
  logic [ROW_COUNT_BITS-1:0]  row_out_q;
  logic [BYTE_COUNT_BITS-1:0] byte_out_q;
  logic                       done_q;

  logic in_accept;
  logic is_err, is_ok, is_eof_mark;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // first payload byte decode
  always_comb begin
    is_err      = (data_byte_i == ERR_MARK);
    is_ok       = (data_byte_i == OK_MARK);
    is_eof_mark = (data_byte_i == EOF_MARK);
  end

  // next parse state for the byte at the input
  always_comb begin
    logic plain;
    logic [LenBits-1:0] len_cur;
    plain     = 1'b0;
    done_d    = 1'b0;
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    pkt_len_d = pkt_len_q;
    left_d    = left_q;
    first_d   = first_q;
    eof_d     = eof_q;
    resp_d    = resp_q;
    cols_d    = cols_q;
    rows_d    = rows_q;
    bytes_d   = bytes_q;

    if (starts_response_i) begin
      phase_d   = PH_HEADER;
      hdr_idx_d = HDR_LEN_B0;
      pkt_len_d = '0;
      left_d    = '0;
      first_d   = 1'b1;
      eof_d     = EOF_NONE;
      resp_d    = ST_BUSY;
      cols_d    = '0;
      rows_d    = '0;
      bytes_d   = '0;
    end

    len_cur = pkt_len_d;

    if (resp_d == ST_BUSY) begin
      if (~&bytes_d) begin
        bytes_d = bytes_d + BYTE_COUNT_BITS'(1);
      end

      if (phase_d == PH_HEADER) begin
        case (hdr_idx_d)
          HDR_LEN_B0: begin
            pkt_len_d = {16'h0000, data_byte_i};
            hdr_idx_d = HDR_LEN_B1;
          end
          HDR_LEN_B1: begin
            pkt_len_d[15:8] = data_byte_i;
            hdr_idx_d = HDR_LEN_B2;
          end
          HDR_LEN_B2: begin
            pkt_len_d[23:16] = data_byte_i;
            hdr_idx_d = HDR_SEQ;
          end
          default: begin
            // sequence byte closes the header
            hdr_idx_d = HDR_LEN_B0;
            left_d    = pkt_len_d;
            if (pkt_len_d == '0) begin
              plain = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        endcase
      end else begin
        if (left_d == len_cur) begin
          if (first_d) begin
            if (is_err) begin
              first_d = 1'b0;
              phase_d = PH_FINAL_ERR;
            end else if (is_ok) begin
              first_d = 1'b0;
              phase_d = PH_FINAL_OK;
            end else begin
              plain = 1'b1;
            end
          end else if (is_err) begin
            if (eof_d != EOF_TWO) begin
              eof_d = eof_d + EofCntBits'(1);
            end
            phase_d = PH_FINAL_ERR;
          end else if (is_eof_mark && (len_cur < EOF_LEN_LIMIT)) begin
            if (eof_d == EOF_NONE) begin
              eof_d = EOF_ONE;
            end else begin
              eof_d   = EOF_TWO;
              phase_d = PH_FINAL_OK;
            end
          end else begin
            plain = 1'b1;
          end
        end

        left_d = left_d - LenBits'(1);
        if (left_d == '0) begin
          if (phase_d == PH_FINAL_OK) begin
            resp_d = ST_DONE_OK;
            done_d = 1'b1;
          end else if (phase_d == PH_FINAL_ERR) begin
            resp_d = ST_DONE_ERR;
            done_d = 1'b1;
          end
          phase_d = PH_HEADER;
        end
      end

      // ordinary packet: column-count, column definition or row
      if (plain) begin
        if (first_d) begin
          first_d = 1'b0;
        end else if (eof_d == EOF_NONE) begin
          if (~&cols_d) begin
            cols_d = cols_d + ColBits'(1);
          end
        end else if (~&rows_d) begin
          rows_d = rows_d + ROW_COUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hdr_idx_q <= HDR_LEN_B0;
      pkt_len_q <= '0;
      left_q    <= '0;
      first_q   <= 1'b1;
      eof_q     <= EOF_NONE;
      resp_q    <= ST_BUSY;
      cols_q    <= '0;
      rows_q    <= '0;
      bytes_q   <= '0;
    end else if (in_accept) begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      pkt_len_q <= pkt_len_d;
      left_q    <= left_d;
      first_q   <= first_d;
      eof_q     <= eof_d;
      resp_q    <= resp_d;
      cols_q    <= cols_d;
      rows_q    <= rows_d;
      bytes_q   <= bytes_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      status_q   <= resp_d;
      col_out_q  <= cols_d;
      row_out_q  <= rows_d;
      byte_out_q <= bytes_d;
      done_q     <= done_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign column_count_o  = col_out_q;
  assign row_count_o     = row_out_q;
  assign byte_count_o    = byte_out_q;
  assign response_done_o = done_q;

endmodule

FILE: sim/sqlrs_sniffer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlrs_sniffer_checker
// Watches both channels of the result-set sniffer, tracks the response parse
// on every accepted byte and compares each result item in order.
// ----------------------------------------------------------------------------
module sqlrs_sniffer_checker
  import sqlrs_pkg::*;
#(
  parameter int unsigned ROW_COUNT_BITS  = 32,
  parameter int unsigned BYTE_COUNT_BITS = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [7:0]                 data_byte_i,
  input  logic                       starts_response_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [1:0]                 status_i,
  input  logic [ColBits-1:0]         column_count_i,
  input  logic [ROW_COUNT_BITS-1:0]  row_count_i,
  input  logic [BYTE_COUNT_BITS-1:0] byte_count_i,
  input  logic                       response_done_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);

  typedef struct packed {
    status_e                    status;
    logic [ColBits-1:0]         columns;
    logic [ROW_COUNT_BITS-1:0]  rows;
    logic [BYTE_COUNT_BITS-1:0] bytes_in;
    logic                       done;
  } tally_t;

  phase_e                     phase;
  logic [HdrIdxBits-1:0]      hdr_idx;
  logic [LenBits-1:0]         pkt_len;
  logic [LenBits-1:0]         left;
  logic                       first_pkt;
  logic [EofCntBits-1:0]      eof_cnt;
  status_e                    rsp_status;
  logic [ColBits-1:0]         seen_cols;
  logic [ROW_COUNT_BITS-1:0]  seen_rows;
  logic [BYTE_COUNT_BITS-1:0] seen_bytes;

  tally_t      tally_q[$];
  int unsigned fails;
  int unsigned reported;

  function automatic void clear_parse();
    phase      = PH_HEADER;
    hdr_idx    = HDR_LEN_B0;
    pkt_len    = '0;
    left       = '0;
    first_pkt  = 1'b1;
    eof_cnt    = EOF_NONE;
    rsp_status = ST_BUSY;
    seen_cols  = '0;
    seen_rows  = '0;
    seen_bytes = '0;
  endfunction

  // column-count packet, column definition or row, by how far the parse got
  function automatic void bump_packet();
    if (first_pkt) begin
      first_pkt = 1'b0;
    end else if (eof_cnt == EOF_NONE) begin
      if (seen_cols != '1) seen_cols++;
    end else if (seen_rows != '1) begin
      seen_rows++;
    end
  endfunction

  function automatic tally_t parse_byte(input logic [7:0] b, input logic mark);
    tally_t t;
    logic   done;
    done = 1'b0;
    if (mark) clear_parse();
    if (rsp_status == ST_BUSY) begin
      if (seen_bytes != '1) seen_bytes++;
      if (phase == PH_HEADER) begin
        if (hdr_idx != HDR_SEQ) begin
          if (hdr_idx == HDR_LEN_B0) pkt_len = '0;
          pkt_len = pkt_len | ({16'd0, b} << (8 * hdr_idx));
          hdr_idx++;
        end else begin
          hdr_idx = HDR_LEN_B0;
          left    = pkt_len;
          if (pkt_len == '0) bump_packet();
          else phase = PH_PAYLOAD;
        end
      end else begin
        // first payload byte decides the packet kind
        if (left == pkt_len) begin
          if (first_pkt) begin
            if (b == ERR_MARK) begin
              first_pkt = 1'b0;
              phase     = PH_FINAL_ERR;
            end else if (b == OK_MARK) begin
              first_pkt = 1'b0;
              phase     = PH_FINAL_OK;
            end else begin
              bump_packet();
            end
          end else if (b == ERR_MARK) begin
            if (eof_cnt < EOF_TWO) eof_cnt++;
            phase = PH_FINAL_ERR;
          end else if (b == EOF_MARK && pkt_len < EOF_LEN_LIMIT) begin
            if (eof_cnt == EOF_NONE) begin
              eof_cnt = EOF_ONE;
            end else begin
              eof_cnt = EOF_TWO;
              phase   = PH_FINAL_OK;
            end
          end else begin
            bump_packet();
          end
        end
        left--;
        if (left == '0) begin
          if (phase == PH_FINAL_OK) begin
            rsp_status = ST_DONE_OK;
            done       = 1'b1;
          end else if (phase == PH_FINAL_ERR) begin
            rsp_status = ST_DONE_ERR;
            done       = 1'b1;
          end
          phase = PH_HEADER;
        end
      end
    end
    t.status   = rsp_status;
    t.columns  = seen_cols;
    t.rows     = seen_rows;
    t.bytes_in = seen_bytes;
    t.done     = done;
    return t;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tally_t got;
    tally_t want;
    if (!rst_ni) begin
      clear_parse();
      tally_q.delete();
      fails        = 0;
      reported     = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // the result taken now belongs to a byte taken at an earlier edge
      if (out_valid_i && !out_stall_i) begin
        got = {status_i, column_count_i, row_count_i, byte_count_i, response_done_i};
        if (tally_q.size() == 0) begin
          fails++;
          if (reported < 10) begin
            reported++;
            $display("%t: result item with nothing expected: status %0d cols %0d",
                     $realtime, got.status, got.columns);
          end
        end else begin
          want = tally_q.pop_front();
          if (got.status !== want.status || got.columns !== want.columns ||
              got.rows !== want.rows || got.bytes_in !== want.bytes_in ||
              got.done !== want.done) begin
            fails++;
            if (reported < 10) begin
              reported++;
              $display("%t: mismatch exp st %0d col %0d row %0d byte %0d done %0d",
                       $realtime, want.status, want.columns, want.rows,
                       want.bytes_in, want.done);
              $display("%t:          got st %0d col %0d row %0d byte %0d done %0d",
                       $realtime, got.status, got.columns, got.rows,
                       got.bytes_in, got.done);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        tally_q.push_back(parse_byte(data_byte_i, starts_response_i));
      end
      fail_count_o <= fails;
      pending_o    <= tally_q.size();
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the result-set packet sniffer: feeds framed query responses
// (ok, error, result sets, cut-off and garbage streams) in random bursts
// against a randomly stalling receiver; the checker scores every result.
// ----------------------------------------------------------------------------
module testbench;
  import sqlrs_pkg::*;

  localparam int unsigned RowBits   = 32;
  localparam int unsigned ByteBits  = 48;
  localparam int unsigned ItemTotal = 525;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic [7:0]          data_byte  = 8'd0;
  logic                start_mark = 1'b0;
  logic                out_stall  = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [1:0]          status;
  logic [ColBits-1:0]  column_count;
  logic [RowBits-1:0]  row_count;
  logic [ByteBits-1:0] byte_count;
  logic                response_done;
  int unsigned         fail_count;
  int unsigned         pending;

  logic [7:0] stream_q[$];
  logic       mark_q[$];

  always #2 clk = ~clk;

  sql_resultset_packet_sniffer_top #(
    .ROW_COUNT_BITS (RowBits),
    .BYTE_COUNT_BITS(ByteBits)
  ) DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .starts_response_i(start_mark),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .column_count_o   (column_count),
    .row_count_o      (row_count),
    .byte_count_o     (byte_count),
    .response_done_o  (response_done)
  );

  sqlrs_sniffer_checker #(
    .ROW_COUNT_BITS (RowBits),
    .BYTE_COUNT_BITS(ByteBits)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .data_byte_i      (data_byte),
    .starts_response_i(start_mark),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .column_count_i   (column_count),
    .row_count_i      (row_count),
    .byte_count_i     (byte_count),
    .response_done_i  (response_done),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  task automatic put_byte(input logic [7:0] b, input logic m);
    stream_q.push_back(b);
    mark_q.push_back(m);
  endtask

  // 3-byte little-endian length, sequence byte, then lead byte and filler
  task automatic put_packet(input logic [23:0] len, input logic [7:0] lead, input logic m);
    put_byte(len[7:0], m);
    put_byte(len[15:8], 1'b0);
    put_byte(len[23:16], 1'b0);
    put_byte(8'($urandom), 1'b0);
    for (int i = 0; i < len; i++) put_byte((i == 0) ? lead : 8'($urandom), 1'b0);
  endtask

  function automatic logic [23:0] pick_len();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 3) return 24'd0;
    if (roll == 19) return 24'($urandom_range(20, 48));
    return 24'($urandom_range(1, 12));
  endfunction

  // lead byte of a packet that neither ends the response nor is an eof
  function automatic logic [7:0] pick_lead(input logic [23:0] len, input bit opening);
    logic [7:0] b;
    // long packet led by the eof mark is an ordinary packet
    if (len >= EOF_LEN_LIMIT && $urandom_range(0, 3) == 0) return EOF_MARK;
    do begin
      b = 8'($urandom);
    end while (b == ERR_MARK || (opening && b == OK_MARK) ||
               (!opening && b == EOF_MARK && len < EOF_LEN_LIMIT));
    return b;
  endfunction

  task automatic put_result_set();
    int unsigned base;
    int unsigned cut;
    logic [23:0] len;
    base = stream_q.size();
    len  = pick_len();
    put_packet(len, pick_lead(len, 1'b1), $urandom_range(0, 15) != 0);
    repeat ($urandom_range(0, 4)) begin
      len = pick_len();
      put_packet(len, pick_lead(len, 1'b0), 1'b0);
    end
    if ($urandom_range(0, 7) == 0) begin
      put_packet(24'($urandom_range(1, 10)), ERR_MARK, 1'b0);
    end else begin
      put_packet(24'($urandom_range(1, 8)), EOF_MARK, 1'b0);
      repeat ($urandom_range(0, 5)) begin
        len = pick_len();
        put_packet(len, pick_lead(len, 1'b0), 1'b0);
      end
      if ($urandom_range(0, 3) == 0) put_packet(24'($urandom_range(1, 10)), ERR_MARK, 1'b0);
      else put_packet(24'($urandom_range(1, 8)), EOF_MARK, 1'b0);
    end
    // cut off part way, the next start mark takes over
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(base + 1, stream_q.size() - 1);
      while (stream_q.size() > cut) begin
        void'(stream_q.pop_back());
        void'(mark_q.pop_back());
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic build_stimulus();
    int unsigned kind;
    // ok response with no start mark right after reset
    put_packet(24'd1, OK_MARK, 1'b0);
    put_byte(8'h5A, 1'b0);
    // one column, an eof, then an error in the row phase
    put_packet(24'd1, 8'h02, 1'b1);
    put_packet(24'd0, 8'h00, 1'b0);
    put_packet(24'd1, EOF_MARK, 1'b0);
    put_packet(24'd1, ERR_MARK, 1'b0);
    while (stream_q.size() < ItemTotal) begin
      kind = $urandom_range(0, 8);
      if (kind < 6) begin
        put_result_set();
      end else if (kind == 6) begin
        put_packet(24'($urandom_range(1, 8)), OK_MARK, 1'b1);
      end else if (kind == 7) begin
        put_packet(24'($urandom_range(1, 8)), ERR_MARK, 1'b1);
      end else begin
        put_byte(8'($urandom), 1'b1);
        repeat ($urandom_range(3, 15)) begin
          put_byte(8'($urandom), $urandom_range(0, 15) == 0);
        end
      end
    end
  endtask

  initial begin : sender
    int unsigned burst;
    int unsigned gap;
    burst = 0;
    build_stimulus();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < stream_q.size(); i++) begin
      // let everything drain once mid-run
      if (i == stream_q.size() / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      data_byte  <= stream_q[i];
      start_mark <= mark_q[i];
      in_valid   <= 1'b1;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst--;
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sql_resultset_packet_sniffer_top regression: pass");
    end else begin
      $display("sql_resultset_packet_sniffer_top regression: fail");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned cyc;
    int unsigned mode;
    cyc  = 0;
    mode = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 900 == 250) begin
        // long hold-off while the sender keeps offering items
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
      end else begin
        if (cyc % 32 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("sql_resultset_packet_sniffer_top regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
sv/sqlrs_pkg.sv
sv/sql_resultset_packet_sniffer_top.sv
sim/sqlrs_sniffer_checker.sv
sim/testbench.sv
